### src/lpsc_pkg.sv
// lpsc_pkg: shared types and constants for the letter pool spell check unit
// no dependencies
`default_nettype none

package lpsc_pkg;

    localparam int ALPHABET_SIZE_DEF = 26;
    localparam int COUNT_BITS_DEF    = 8;

    localparam int          CHAR_W       = 8;
    localparam int          OP_W         = 2;
    localparam int          TOTAL_OUT_W  = 13;
    localparam logic [CHAR_W-1:0] START_RESET = 8'd97;
    localparam logic [CHAR_W-1:0] CHAR_END    = 8'd0;

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_PHRASE = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    typedef struct packed {
        logic is_letter;
        logic is_blank;
        logic is_end;
    } t_char_class;

endpackage

`default_nettype wire

### src/lpsc_char_class.sv
// lpsc_char_class: sorts one character into letter, ignorable or end of phrase
// depends on lpsc_pkg
`default_nettype none

module lpsc_char_class
    import lpsc_pkg::*;
#(
    parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF,
    localparam int IDX_W = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1
) (
    input  wire logic [CHAR_W-1:0] i_char,
    input  wire logic [CHAR_W-1:0] i_start,
    output t_char_class            o_class,
    output logic [IDX_W-1:0]       o_idx
);

    localparam logic [CHAR_W:0] ALPHA_LIM = (CHAR_W+1)'(ALPHABET_SIZE);

    logic [CHAR_W-1:0] w_dist;
    logic              w_space;
    logic              w_punct;

    assign w_dist = i_char - i_start;
    assign o_idx  = w_dist[IDX_W-1:0];

    // c locale whitespace and punctuation
    always_comb begin
        w_space = (i_char inside {[8'h09:8'h0D], 8'h20});
        w_punct = (i_char inside {[8'h21:8'h2F], [8'h3A:8'h40], [8'h5B:8'h60], [8'h7B:8'h7E]});
    end

    assign o_class.is_letter = ({1'b0, w_dist} < ALPHA_LIM);
    assign o_class.is_blank  = w_space | w_punct;
    assign o_class.is_end    = (i_char == CHAR_END);

endmodule

`default_nettype wire

### src/letter_pool_spell_check_unit.sv
// Letter pool spell check unit: one item per clock sustained while i_out_stall is low, the result
// reaching the outputs through the input register, then the result register. Each item touches
// one pool or phrase counter, chosen by the character, and clears of the pool or phrase counts act on
// all counters at once; throughput is set by that single read-modify-write per cycle. Pool totals
// are shown saturated at 8191. The user must write the alphabet start register only while the unit
// is idle; the unit itself does not enforce it. Depends on lpsc_pkg and lpsc_char_class.
`default_nettype none

module letter_pool_spell_check_unit
    import lpsc_pkg::*;
#(
    parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF,
    parameter int COUNT_BITS    = COUNT_BITS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,

    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CHAR_W-1:0]      i_cfg_data,

    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire logic [OP_W-1:0]        i_op,
    input  wire logic [CHAR_W-1:0]      i_character,

    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output logic                        o_phrase_ok,
    output logic                        o_phrase_done,
    output logic [TOTAL_OUT_W-1:0]      o_pool_total,
    output logic                        o_clamped
);

    localparam int IDX_W      = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
    localparam int COUNT_MAXI = (1 << COUNT_BITS) - 1;
    localparam int TOTAL_BITS = $clog2(ALPHABET_SIZE * COUNT_MAXI + 1);
    localparam int SAT_W      = (TOTAL_BITS > TOTAL_OUT_W) ? TOTAL_BITS : TOTAL_OUT_W;
    localparam logic [COUNT_BITS-1:0]  COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [SAT_W-1:0]       TOTAL_SAT = SAT_W'((1 << TOTAL_OUT_W) - 1);
    localparam logic [TOTAL_BITS-1:0]  TOTAL_ONE = TOTAL_BITS'(1);

    logic [CHAR_W-1:0]     r_start;

    logic                  r_in_valid;
    t_op                   r_op;
    logic [CHAR_W-1:0]     r_char;

    logic [COUNT_BITS-1:0] r_pool   [ALPHABET_SIZE];
    logic [COUNT_BITS-1:0] n_pool   [ALPHABET_SIZE];
    logic [COUNT_BITS-1:0] r_phrase [ALPHABET_SIZE];
    logic [COUNT_BITS-1:0] n_phrase [ALPHABET_SIZE];
    logic                  r_failed;
    logic                  n_failed;
    logic [TOTAL_BITS-1:0] r_total;
    logic [TOTAL_BITS-1:0] n_total;

    logic                   r_out_valid;
    logic                   r_ok;
    logic                   n_ok;
    logic                   r_done;
    logic                   n_done;
    logic                   r_clamped;
    logic                   n_clamped;
    logic [TOTAL_OUT_W-1:0] r_pool_total;
    logic [TOTAL_OUT_W-1:0] n_pool_total;

    logic                  w_adv;
    t_char_class           w_class;
    logic [IDX_W-1:0]      w_idx;
    logic [COUNT_BITS-1:0] w_pool_cur;
    logic [COUNT_BITS-1:0] w_phrase_cur;
    logic [COUNT_BITS:0]   w_phrase_inc;
    logic [SAT_W-1:0]      w_total_wide;

    assign o_cfg_ready = 1'b1;

    assign w_adv      = r_in_valid & (~r_out_valid | ~i_out_stall);
    assign o_in_stall = r_in_valid & ~w_adv;

    lpsc_char_class #(
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_char_class (
        .i_char  (r_char),
        .i_start (r_start),
        .o_class (w_class),
        .o_idx   (w_idx)
    );

    assign w_pool_cur   = r_pool[w_idx];
    assign w_phrase_cur = r_phrase[w_idx];
    assign w_phrase_inc = {1'b0, w_phrase_cur} + (COUNT_BITS+1)'(1);

    always_comb begin
        n_pool    = r_pool;
        n_phrase  = r_phrase;
        n_failed  = r_failed;
        n_total   = r_total;
        n_clamped = 1'b0;
        n_done    = 1'b0;
        n_ok      = ~r_failed;

        case (r_op)
            OP_ADD: begin
                if (w_class.is_letter) begin
                    if (w_pool_cur == COUNT_MAX) begin
                        n_clamped = 1'b1;
                    end else begin
                        n_pool[w_idx] = w_pool_cur + COUNT_BITS'(1);
                        n_total       = r_total + TOTAL_ONE;
                    end
                end
            end
            OP_REMOVE: begin
                if (w_class.is_letter) begin
                    if (w_pool_cur == '0) begin
                        n_clamped = 1'b1;
                    end else begin
                        n_pool[w_idx] = w_pool_cur - COUNT_BITS'(1);
                        n_total       = r_total - TOTAL_ONE;
                    end
                end
            end
            OP_CLEAR: begin
                for (int i = 0; i < ALPHABET_SIZE; i++) begin
                    n_pool[i] = '0;
                end
                n_total = '0;
            end
            OP_PHRASE: begin
                if (w_class.is_end) begin
                    n_done   = 1'b1;
                    n_failed = 1'b0;
                    for (int i = 0; i < ALPHABET_SIZE; i++) begin
                        n_phrase[i] = '0;
                    end
                end else if (!r_failed) begin
                    if (w_class.is_letter) begin
                        if (w_phrase_inc > {1'b0, w_pool_cur}) begin
                            n_failed = 1'b1;
                        end
                        // count holds at its maximum
                        if (w_phrase_cur != COUNT_MAX) begin
                            n_phrase[w_idx] = w_phrase_inc[COUNT_BITS-1:0];
                        end
                    end else if (!w_class.is_blank) begin
                        n_failed = 1'b1;
                    end
                    n_ok = ~n_failed;
                end
            end
            default: begin
                n_ok = ~r_failed;
            end
        endcase

        w_total_wide = SAT_W'(n_total);
        if (w_total_wide > TOTAL_SAT) begin
            n_pool_total = {TOTAL_OUT_W{1'b1}};
        end else begin
            n_pool_total = w_total_wide[TOTAL_OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= START_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_start <= i_cfg_data;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_op   <= t_op'(i_op);
            r_char <= i_character;
        end
    end

    // counter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ALPHABET_SIZE; i++) begin
                r_pool[i]   <= '0;
                r_phrase[i] <= '0;
            end
            r_failed <= 1'b0;
            r_total  <= '0;
        end else if (w_adv) begin
            r_pool   <= n_pool;
            r_phrase <= n_phrase;
            r_failed <= n_failed;
            r_total  <= n_total;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_ok         <= n_ok;
            r_done       <= n_done;
            r_clamped    <= n_clamped;
            r_pool_total <= n_pool_total;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_phrase_ok   = r_ok;
    assign o_phrase_done = r_done;
    assign o_pool_total  = r_pool_total;
    assign o_clamped     = r_clamped;

endmodule

`default_nettype wire

### verif/letter_pool_spell_check_unit_tb.sv
`timescale 1ns / 1ps
// letter_pool_spell_check_unit_tb: self-checking bench for the letter pool spell check unit,
// random bursts of pool and phrase items checked against an in-bench predictor of unit state
// depends on lpsc_pkg and letter_pool_spell_check_unit

module letter_pool_spell_check_unit_tb;
    import lpsc_pkg::*;

    localparam int ALPHA_N   = 26;
    localparam int COUNT_MAX = 255;
    localparam int TOTAL_SAT = 8191;

    typedef struct packed {
        t_op              op;
        logic [CHAR_W-1:0] ch;
    } t_char_item;

    typedef struct packed {
        logic                   ok;
        logic                   done;
        logic [TOTAL_OUT_W-1:0] total;
        logic                   clamped;
    } t_verdict;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic [CHAR_W-1:0]      i_cfg_data = '0;
    logic                   i_in_valid = 1'b0;
    logic [OP_W-1:0]        i_op = '0;
    logic [CHAR_W-1:0]      i_character = '0;
    logic                   i_out_stall = 1'b0;
    logic                   o_cfg_ready;
    logic                   o_in_stall;
    logic                   o_out_valid;
    logic                   o_phrase_ok;
    logic                   o_phrase_done;
    logic [TOTAL_OUT_W-1:0] o_pool_total;
    logic                   o_clamped;

    letter_pool_spell_check_unit DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_op         (i_op),
        .i_character  (i_character),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_phrase_ok  (o_phrase_ok),
        .o_phrase_done(o_phrase_done),
        .o_pool_total (o_pool_total),
        .o_clamped    (o_clamped)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // predicted state of the unit
    logic [7:0]        pool_cnt [ALPHA_N];
    logic [7:0]        phrase_cnt [ALPHA_N];
    logic              phrase_bad;
    int                pool_sum;
    logic [CHAR_W-1:0] alpha_start;

    t_char_item char_q [$];
    t_verdict   verdict_q [$];
    int         queued;
    int         errors;

    function automatic t_verdict spell_step(input t_op op, input logic [CHAR_W-1:0] ch);
        logic [7:0] d;
        logic       is_letter;
        int         nxt;
        t_verdict   v;
        d = ch - alpha_start;
        is_letter = (d < ALPHA_N);
        v = '0;
        case (op)
            OP_ADD: begin
                if (is_letter) begin
                    if (pool_cnt[d] == COUNT_MAX) begin
                        v.clamped = 1'b1;
                    end else begin
                        pool_cnt[d]++;
                        pool_sum++;
                    end
                end
            end
            OP_REMOVE: begin
                if (is_letter) begin
                    if (pool_cnt[d] == 0) begin
                        v.clamped = 1'b1;
                    end else begin
                        pool_cnt[d]--;
                        pool_sum--;
                    end
                end
            end
            OP_CLEAR: begin
                foreach (pool_cnt[i]) pool_cnt[i] = '0;
                pool_sum = 0;
            end
            default: ;
        endcase
        v.ok = !phrase_bad;
        if (op == OP_PHRASE) begin
            if (ch == CHAR_END) begin
                v.done = 1'b1;
                foreach (phrase_cnt[i]) phrase_cnt[i] = '0;
                phrase_bad = 1'b0;
            end else if (!phrase_bad) begin
                if (is_letter) begin
                    nxt = phrase_cnt[d] + 1;
                    if (nxt > pool_cnt[d]) phrase_bad = 1'b1;
                    phrase_cnt[d] = (nxt > COUNT_MAX) ? 8'(COUNT_MAX) : 8'(nxt);
                end else if (!((ch >= 8'h09 && ch <= 8'h0D) || ch == 8'h20 ||
                               (ch >= 8'h21 && ch <= 8'h2F) || (ch >= 8'h3A && ch <= 8'h40) ||
                               (ch >= 8'h5B && ch <= 8'h60) || (ch >= 8'h7B && ch <= 8'h7E))) begin
                    phrase_bad = 1'b1;
                end
                v.ok = !phrase_bad;
            end
        end
        v.total = (pool_sum > TOTAL_SAT) ? TOTAL_OUT_W'(TOTAL_SAT) : TOTAL_OUT_W'(pool_sum);
        return v;
    endfunction

    // driver
    t_char_item drv_item;
    int         burst_left = 1;
    int         gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                verdict_q.push_back(spell_step(t_op'(i_op), i_character));
            end
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (char_q.size() > 0) begin
                    drv_item = char_q.pop_front();
                    i_in_valid <= 1'b1;
                    i_op <= drv_item.op;
                    i_character <= drv_item.ch;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    int       stall_mode = 0;
    int       stall_left = 0;
    int       stall_tick = 0;
    t_verdict want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (verdict_q.size() == 0) begin
                    $display("%0t: result with none expected: ok %0d done %0d total %0d clamped %0d",
                             $time, o_phrase_ok, o_phrase_done, o_pool_total, o_clamped);
                    errors++;
                end else begin
                    want = verdict_q.pop_front();
                    if (o_phrase_ok !== want.ok) begin
                        $display("%0t: phrase_ok expected %0d got %0d", $time, want.ok, o_phrase_ok);
                        errors++;
                    end
                    if (o_phrase_done !== want.done) begin
                        $display("%0t: phrase_done expected %0d got %0d",
                                 $time, want.done, o_phrase_done);
                        errors++;
                    end
                    if (o_pool_total !== want.total) begin
                        $display("%0t: pool_total expected %0d got %0d",
                                 $time, want.total, o_pool_total);
                        errors++;
                    end
                    if (o_clamped !== want.clamped) begin
                        $display("%0t: clamped expected %0d got %0d", $time, want.clamped, o_clamped);
                        errors++;
                    end
                end
            end
            if (stall_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(20, 200);
            end
            stall_left--;
            stall_tick++;
            case (stall_mode)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= ($urandom_range(0, 3) == 0);
                2: i_out_stall <= ((stall_tick % 5) < 2);
                default: i_out_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    task automatic push(input t_op op, input logic [CHAR_W-1:0] ch);
        t_char_item it;
        it.op = op;
        it.ch = ch;
        char_q.push_back(it);
        queued++;
    endtask

    function automatic logic [CHAR_W-1:0] rand_letter();
        return CHAR_W'(alpha_start + $urandom_range(0, ALPHA_N - 1));
    endfunction

    function automatic logic [CHAR_W-1:0] rand_blank();
        case ($urandom_range(0, 5))
            0: return 8'h20;
            1: return CHAR_W'($urandom_range(8'h09, 8'h0D));
            2: return CHAR_W'($urandom_range(8'h21, 8'h2F));
            3: return CHAR_W'($urandom_range(8'h3A, 8'h40));
            4: return CHAR_W'($urandom_range(8'h5B, 8'h60));
            default: return CHAR_W'($urandom_range(8'h7B, 8'h7E));
        endcase
    endfunction

    // build a pool, then spell a phrase mostly from its letters
    task automatic queue_spelling();
        logic [CHAR_W-1:0] used [$];
        logic [CHAR_W-1:0] c;
        int                r;
        if ($urandom_range(0, 3) == 0) push(OP_CLEAR, CHAR_W'($urandom));
        repeat ($urandom_range(0, 12)) begin
            c = rand_letter();
            used.push_back(c);
            push(OP_ADD, c);
        end
        if ($urandom_range(0, 2) == 0) push(OP_REMOVE, rand_letter());
        repeat ($urandom_range(0, 10)) begin
            r = $urandom_range(0, 19);
            if (r < 12 && used.size() > 0) c = used[$urandom_range(0, used.size() - 1)];
            else if (r < 16) c = rand_blank();
            else if (r < 18) c = rand_letter();
            else c = CHAR_W'($urandom);
            if ($urandom_range(0, 15) == 0) begin
                case ($urandom_range(0, 2))
                    0: push(OP_ADD, c);
                    1: push(OP_REMOVE, c);
                    default: push(OP_CLEAR, c);
                endcase
            end
            push(OP_PHRASE, c);
        end
        push(OP_PHRASE, CHAR_END);
    endtask

    // drive one counter to its maximum, then overrun it with the phrase
    task automatic queue_saturation(input int k);
        logic [CHAR_W-1:0] l;
        l = CHAR_W'(alpha_start + k);
        push(OP_PHRASE, CHAR_END);
        repeat (COUNT_MAX + 2) push(OP_ADD, l);
        repeat (COUNT_MAX + 1) push(OP_PHRASE, l);
        push(OP_PHRASE, l);
        push(OP_PHRASE, CHAR_END);
        push(OP_CLEAR, l);
        repeat (2) push(OP_REMOVE, l);
    endtask

    task automatic queue_random(input int n);
        int target;
        target = queued + n;
        while (queued < target) begin
            case ($urandom_range(0, 9))
                7, 8: repeat ($urandom_range(1, 6))
                    push(t_op'($urandom_range(0, 3)), CHAR_W'($urandom));
                9: repeat ($urandom_range(2, 10))
                    push(($urandom_range(0, 2) != 0) ? OP_ADD : OP_REMOVE, rand_letter());
                default: queue_spelling();
            endcase
        end
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (char_q.size() != 0 || i_in_valid || verdict_q.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_start(input logic [CHAR_W-1:0] v);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        alpha_start = v;
        i_cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        logic [CHAR_W-1:0] starts [$];
        foreach (pool_cnt[i]) begin
            pool_cnt[i] = '0;
            phrase_cnt[i] = '0;
        end
        phrase_bad = 1'b0;
        pool_sum = 0;
        alpha_start = START_RESET;
        queued = 0;
        errors = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        push(OP_ADD, 8'h61);
        push(OP_ADD, 8'h7A);
        push(OP_ADD, 8'h60);
        push(OP_ADD, 8'h7B);
        push(OP_REMOVE, 8'h62);
        push(OP_REMOVE, 8'h61);
        push(OP_PHRASE, 8'h7A);
        push(OP_PHRASE, 8'h20);
        push(OP_PHRASE, 8'h21);
        push(OP_PHRASE, 8'hFF);
        push(OP_PHRASE, 8'h7A);
        push(OP_PHRASE, CHAR_END);
        push(OP_PHRASE, CHAR_END);
        push(OP_PHRASE, 8'h61);
        push(OP_PHRASE, CHAR_END);
        push(OP_CLEAR, 8'hFF);
        push(OP_PHRASE, 8'h7E);
        push(OP_PHRASE, 8'h7F);
        push(OP_PHRASE, CHAR_END);
        push(OP_ADD, 8'h00);
        push(OP_REMOVE, 8'hFF);
        push(OP_ADD, 8'h71);
        push(OP_PHRASE, 8'h71);
        push(OP_REMOVE, 8'h71);
        push(OP_PHRASE, 8'h71);
        push(OP_PHRASE, CHAR_END);
        queue_saturation(ALPHA_N - 1);
        queue_random(150);
        wait_idle();

        starts = '{8'h00, 8'hFF, 8'h20, 8'h41, CHAR_W'($urandom), 8'hC8, START_RESET};
        foreach (starts[i]) begin
            write_start(starts[i]);
            queue_random(100);
            wait_idle();
        end

        if (errors == 0) begin
            $display("letter_pool_spell_check_unit_tb: PASS");
        end else begin
            $display("letter_pool_spell_check_unit_tb: FAIL");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("letter_pool_spell_check_unit_tb: FAIL");
        $finish;
    end

endmodule
